// ===== rtl/ipe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising pair energy package
// Shared constants, types, control structs and helper functions.
// ----------------------------------------------------------------------------
package ipe_pkg;

    // Store geometry and arithmetic widths
    localparam int MAX_SPINS     = 32;
    localparam int COUPLING_BITS = 16;
    localparam int ENERGY_BITS   = 25;

    // Port field widths
    localparam int PATTERN_BITS  = 32;
    localparam int FIELD_IDX_BITS = 5;
    localparam int FIELD_COUP_BITS = 16;
    localparam int CFG_BITS      = 6;
    localparam int SPINS_RESET   = 32;

    // Derived widths
    localparam int IDX_W       = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
    localparam int CNT_W       = $clog2(MAX_SPINS + 1);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int PAIRS       = MAX_SPINS * (MAX_SPINS - 1) / 2;
    localparam int SUM_W       = COUPLING_BITS + $clog2(PAIRS + 1) + 1;
    localparam int ACC_W       = (SUM_W > ENERGY_BITS) ? SUM_W : ENERGY_BITS;

    localparam longint ENERGY_HI = (64'sd1 <<< (ENERGY_BITS - 1)) - 64'sd1;
    localparam longint ENERGY_LO = -ENERGY_HI - 64'sd1;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic signed [COUPLING_BITS-1:0] coup_t;
    typedef logic signed [ACC_W-1:0]         acc_t;
    typedef logic signed [ENERGY_BITS-1:0]   energy_t;
    typedef logic [CNT_W-1:0]                cnt_t;
    typedef logic [ADDR_W-1:0]               addr_t;
    typedef logic [MAX_SPINS-1:0]            spin_vec_t;

    // Top level to evaluation sequencer
    typedef struct packed {
        logic start;
        logic take;
        cnt_t spin_count;
    } ctrl_t;

    // Evaluation sequencer to top level
    typedef struct packed {
        logic    busy;
        logic    done;
        energy_t energy;
    } status_t;

    // Map pattern bits onto spins; spins past the pattern read as -1
    function automatic spin_vec_t spin_vector(input logic [PATTERN_BITS-1:0] p);
        spin_vec_t v;
        v = '0;
        for (int k = 0; k < MAX_SPINS; k++)
        begin
            if (k < PATTERN_BITS)
            begin
                v[k] = p[k[4:0]];
            end
        end
        return v;
    endfunction

    // Clamp the accumulator to the energy range
    function automatic energy_t sat_energy(input acc_t a);
        energy_t e;
        if (a > acc_t'(ENERGY_HI))
        begin
            e = energy_t'(ENERGY_HI);
        end
        else if (a < acc_t'(ENERGY_LO))
        begin
            e = energy_t'(ENERGY_LO);
        end
        else
        begin
            e = energy_t'(a);
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ipe_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one coupling write or one evaluate request.
// ----------------------------------------------------------------------------
interface ipe_item_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      op;
    logic [ipe_pkg::FIELD_IDX_BITS-1:0]        row_index;
    logic [ipe_pkg::FIELD_IDX_BITS-1:0]        col_index;
    logic signed [ipe_pkg::FIELD_COUP_BITS-1:0] coupling_value;
    logic [ipe_pkg::PATTERN_BITS-1:0]          spin_pattern;

    modport source (
        output valid, op, row_index, col_index, coupling_value, spin_pattern,
        input  ready
    );
    modport sink (
        input  valid, op, row_index, col_index, coupling_value, spin_pattern,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/ipe_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one energy value.
// ----------------------------------------------------------------------------
interface ipe_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ipe_pkg::ENERGY_BITS-1:0] energy;

    modport source (
        output valid, energy,
        input  ready
    );
    modport sink (
        input  valid, energy,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/ipe_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the spin count register value.
// ----------------------------------------------------------------------------
interface ipe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ipe_pkg::CFG_BITS-1:0]    spins_in_use;

    modport source (
        output valid, spins_in_use,
        input  ready
    );
    modport sink (
        input  valid, spins_in_use,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/ipe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ipe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/ipe_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Evaluation sequencer
// Walks all pairs i<j below the spin count, reads one coupling per cycle
// and adds or subtracts it into the energy accumulator.
// ----------------------------------------------------------------------------
module ipe_eval (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ipe_pkg::ctrl_t                      ctrl,
    input  wire logic [ipe_pkg::PATTERN_BITS-1:0]    pattern,
    output ipe_pkg::addr_t                           rd_addr,
    input  wire logic [ipe_pkg::COUPLING_BITS-1:0]   rd_data,
    output ipe_pkg::status_t                         status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam int IW = ipe_pkg::IDX_W;

    state_t              state_reg, state_next;
    ipe_pkg::cnt_t       i_reg, i_next;
    ipe_pkg::cnt_t       j_reg, j_next;
    ipe_pkg::cnt_t       n_reg, n_next;
    ipe_pkg::spin_vec_t  spins_reg, spins_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                add_reg, add_next;
    logic                last_reg, last_next;
    ipe_pkg::acc_t       acc_reg, acc_next;
    ipe_pkg::acc_t       coup_ext;
    logic                j_end;
    logic                i_end;

    assign coup_ext = ipe_pkg::acc_t'(ipe_pkg::coup_t'(rd_data));
    assign j_end    = (j_reg == n_reg - ipe_pkg::cnt_t'(1));
    assign i_end    = (i_reg == n_reg - ipe_pkg::cnt_t'(2));
    assign rd_addr  = {i_reg[IW-1:0], j_reg[IW-1:0]};

    // Sequence pairs and accumulate returning reads
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        spins_next  = spins_reg;
        rd_vld_next = 1'b0;
        add_next    = add_reg;
        last_next   = last_reg;
        acc_next    = acc_reg;

        if (rd_vld_reg)
        begin
            acc_next = add_reg ? acc_reg + coup_ext : acc_reg - coup_ext;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    acc_next   = '0;
                    spins_next = ipe_pkg::spin_vector(pattern);
                    n_next     = ctrl.spin_count;
                    i_next     = '0;
                    j_next     = ipe_pkg::cnt_t'(1);
                    if (ctrl.spin_count < ipe_pkg::cnt_t'(2))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rd_vld_next = 1'b1;
                add_next    = spins_reg[i_reg[IW-1:0]] ^ spins_reg[j_reg[IW-1:0]];
                last_next   = j_end && i_end;
                if (j_end)
                begin
                    if (i_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + ipe_pkg::cnt_t'(1);
                        j_next = i_reg + ipe_pkg::cnt_t'(2);
                    end
                end
                else
                begin
                    j_next = j_reg + ipe_pkg::cnt_t'(1);
                end
            end
            ST_DRAIN:
            begin
                if (rd_vld_reg && last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            last_reg   <= last_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        n_reg     <= n_next;
        spins_reg <= spins_next;
        add_reg   <= add_next;
        acc_reg   <= acc_next;
    end

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign status.energy = ipe_pkg::sat_energy(acc_reg);

`ifndef SYNTHESIS
    a_rd_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_RUN))
        else $error("read data valid without a pair issued");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == ST_IDLE)
        else $error("evaluation started while busy");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (j_reg > i_reg) && (j_reg < n_reg))
        else $error("pair indices out of order");
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> state_reg == ST_DONE || state_reg == ST_IDLE)
        else $error("left done state without handing off the result");
`endif

endmodule
`default_nettype wire

// ===== rtl/ising_pair_energy_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ising pair energy core
// Stores pair couplings and evaluates the energy of a spin pattern.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  item     | in  | op, row_index, col_index, coupling_value, spin_pattern
//  result   | out | energy (one per evaluate transaction)
//  cfg      | in  | spins_in_use
//
//  A write transaction is stored in the coupling RAM as it is accepted. An
//  evaluate transaction reads the n*(n-1)/2 pair couplings for n of two or
//  more spins in use; below two spins it reads none. The one coupling RAM read
//  port delivers one coupling per cycle.
//  Item ready drops from an evaluate transaction until its energy moves into
//  the output register; writes are accepted while a result waits there.
//  Reset sets the spin count to 32; the coupling RAM is not cleared.
// ----------------------------------------------------------------------------
module ising_pair_energy_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ipe_item_if.sink        item,
    ipe_result_if.source    result,
    ipe_cfg_if.sink         cfg
);

    localparam int IW = ipe_pkg::IDX_W;

    logic [ipe_pkg::CFG_BITS-1:0]   spins_reg;
    logic                           out_valid_reg, out_valid_next;
    ipe_pkg::energy_t               energy_reg;
    ipe_pkg::ctrl_t                 ctrl;
    ipe_pkg::status_t               status;
    ipe_pkg::addr_t                 rd_addr;
    ipe_pkg::addr_t                 wr_addr;
    logic [ipe_pkg::COUPLING_BITS-1:0] rd_data;
    ipe_pkg::coup_t                 wr_data;
    logic                           item_acc;
    logic                           wr_en;
    logic                           in_range;

    // Accept items while no evaluation is pending
    assign item.ready = ~status.busy;
    assign item_acc   = item.valid & item.ready;

    // Coupling write
    assign in_range = (int'(item.row_index) < ipe_pkg::MAX_SPINS)
                   && (int'(item.col_index) < ipe_pkg::MAX_SPINS);
    assign wr_en    = item_acc && (item.op == ipe_pkg::OP_WRITE) && in_range;
    assign wr_addr  = {IW'(item.row_index), IW'(item.col_index)};
    assign wr_data  = ipe_pkg::coup_t'(item.coupling_value);

    // Evaluation control
    assign ctrl.start      = item_acc && (item.op == ipe_pkg::OP_EVAL);
    assign ctrl.take       = status.done & (~out_valid_reg | result.ready);
    assign ctrl.spin_count = (int'(spins_reg) > ipe_pkg::MAX_SPINS)
                           ? ipe_pkg::cnt_t'(ipe_pkg::MAX_SPINS)
                           : ipe_pkg::cnt_t'(spins_reg);

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spins_reg <= ipe_pkg::CFG_BITS'(ipe_pkg::SPINS_RESET);
        end
        else if (cfg.valid && cfg.ready)
        begin
            spins_reg <= cfg.spins_in_use;
        end
    end

    // Output register: load on take, drop on transaction
    assign out_valid_next = ctrl.take | (out_valid_reg & ~result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            energy_reg <= status.energy;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.energy = energy_reg;

    ipe_ram #(
        .WIDTH (ipe_pkg::COUPLING_BITS),
        .DEPTH (ipe_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ipe_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pattern (item.spin_pattern),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .status  (status)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising pair energy core testbench
// Checks coupling writes and energy evaluations across several spin counts.
// It writes each coupling before any evaluation reads it, so no unwritten entry is ever read.
// Both channels stall at random. Every energy is compared with a prediction
// kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import ipe_pkg::*;

    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    RANDOM_PHASES  = 8;
    localparam int    PHASE_ITEMS    = 85;
    localparam int    SETTLE_CYCLES  = 8;
    localparam coup_t COUP_MIN       = 16'sh8000;
    localparam coup_t COUP_MAX       = 16'sh7FFF;

    // Mirror of the coupling store plus the queue of energies still owed
    class energy_tracker;
        coup_t   couplings [STORE_DEPTH];
        int      spin_count;
        energy_t pending_energy [$];
        int      errors;
        int      writes;
        int      evals;
        int      settings;

        function new();
            spin_count = SPINS_RESET;
            errors     = 0;
            writes     = 0;
            evals      = 0;
            settings   = 0;
            foreach (couplings[k])
            begin
                couplings[k] = '0;
            end
        endfunction

        function void set_spins(logic [CFG_BITS-1:0] value);
            spin_count = int'(value);
            settings++;
        endfunction

        // Sum each upper-triangle coupling with the sign of its spin pair
        function energy_t predict_energy(logic [PATTERN_BITS-1:0] pattern);
            longint total;
            int     n;
            logic   si;
            logic   sj;
            total = 0;
            n = (spin_count > MAX_SPINS) ? MAX_SPINS : spin_count;
            for (int i = 0; i < n; i++)
            begin
                si = (i < PATTERN_BITS) ? pattern[i] : 1'b0;
                for (int j = i + 1; j < n; j++)
                begin
                    sj = (j < PATTERN_BITS) ? pattern[j] : 1'b0;
                    if (si == sj)
                    begin
                        total -= longint'(couplings[i * MAX_SPINS + j]);
                    end
                    else
                    begin
                        total += longint'(couplings[i * MAX_SPINS + j]);
                    end
                end
            end
            if (total > ENERGY_HI)
            begin
                total = ENERGY_HI;
            end
            if (total < ENERGY_LO)
            begin
                total = ENERGY_LO;
            end
            return energy_t'(total);
        endfunction

        // Record an accepted item transaction
        function void note_item(logic op, logic [FIELD_IDX_BITS-1:0] row,
                                logic [FIELD_IDX_BITS-1:0] col, coup_t value,
                                logic [PATTERN_BITS-1:0] pattern);
            if (op == OP_WRITE)
            begin
                if (int'(row) < MAX_SPINS && int'(col) < MAX_SPINS)
                begin
                    couplings[int'(row) * MAX_SPINS + int'(col)] = value;
                end
                writes++;
            end
            else
            begin
                pending_energy.push_back(predict_energy(pattern));
                evals++;
            end
        endfunction

        // Compare an accepted result transaction with the oldest prediction
        function void check_energy(energy_t got);
            energy_t expected;
            if (pending_energy.size() == 0)
            begin
                $display("%0t: energy %0d arrived with no evaluation outstanding",
                         $time, got);
                errors++;
            end
            else
            begin
                expected = pending_energy.pop_front();
                if (got !== expected)
                begin
                    $display("%0t: energy mismatch: expected %0d, actual %0d",
                             $time, expected, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    bit            steady;
    int            idle_cycles;
    int            stall_left;
    energy_tracker tracker;

    ipe_item_if   item_ch ();
    ipe_result_if result_ch ();
    ipe_cfg_if    cfg_ch ();

    ising_pair_energy_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observe all three channels and guard against a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                tracker.set_spins(cfg_ch.spins_in_use);
            end
            if (item_ch.valid && item_ch.ready)
            begin
                tracker.note_item(item_ch.op, item_ch.row_index, item_ch.col_index,
                                  item_ch.coupling_value, item_ch.spin_pattern);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                tracker.check_energy(result_ch.energy);
            end
            if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, no transaction in %0d cycles",
                         $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stall the result channel at random, except during the steady stretch
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 6)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 3);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    function automatic coup_t random_coupling();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return COUP_MIN;
        end
        if (pick == 1)
        begin
            return COUP_MAX;
        end
        return coup_t'($urandom);
    endfunction

    function automatic logic [PATTERN_BITS-1:0] random_pattern();
        logic [PATTERN_BITS-1:0] one_hot;
        one_hot = '0;
        one_hot[$urandom_range(0, PATTERN_BITS - 1)] = 1'b1;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // Present one item transaction and hold it until accepted
    task automatic send_item(logic op, logic [FIELD_IDX_BITS-1:0] row,
                             logic [FIELD_IDX_BITS-1:0] col, coup_t value,
                             logic [PATTERN_BITS-1:0] pattern);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 6) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.op             <= op;
        item_ch.row_index      <= row;
        item_ch.col_index      <= col;
        item_ch.coupling_value <= value;
        item_ch.spin_pattern   <= pattern;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_coupling(int row, int col, coup_t value);
        send_item(OP_WRITE, row[FIELD_IDX_BITS-1:0], col[FIELD_IDX_BITS-1:0], value,
                  $urandom);
    endtask

    task automatic evaluate(logic [PATTERN_BITS-1:0] pattern);
        send_item(OP_EVAL, FIELD_IDX_BITS'($urandom), FIELD_IDX_BITS'($urandom),
                  coup_t'($urandom), pattern);
    endtask

    // Drop item valid and hold until every owed energy has arrived
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (tracker.pending_energy.size() > 0) @(negedge clk);
    endtask

    // Write the spin count once the core is idle
    task automatic set_spin_count(int count);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.spins_in_use <= count[CFG_BITS-1:0];
        cfg_ch.valid        <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int count;
        int pick;
        int row;
        int col;
        tracker                = new();
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        idle_cycles            = 0;
        stall_left             = 0;
        item_ch.valid          = 1'b0;
        item_ch.op             = OP_WRITE;
        item_ch.row_index      = '0;
        item_ch.col_index      = '0;
        item_ch.coupling_value = '0;
        item_ch.spin_pattern   = '0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.spins_in_use    = '0;

        // Hold reset, then release it on a falling clock edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single pair: both coupling extremes, equal and opposite spins,
        // upper pattern bits ignored
        set_spin_count(2);
        write_coupling(0, 1, COUP_MIN);
        evaluate(32'h0000_0000);
        evaluate(32'h0000_0001);
        evaluate(32'hFFFF_FFFF);
        evaluate(32'hFFFF_FFFE);
        write_coupling(0, 1, COUP_MAX);
        evaluate(32'h0000_0002);
        evaluate(32'h0000_0003);

        // Entries on or below the diagonal are stored but never read
        write_coupling(1, 0, 16'sh1234);
        write_coupling(7, 7, -16'sd1);
        write_coupling(31, 31, COUP_MAX);
        evaluate(32'h0000_0001);

        // No pairs with zero or one spin
        set_spin_count(0);
        evaluate(32'hFFFF_FFFF);
        set_spin_count(1);
        evaluate(32'h0000_0005);

        // Fill the whole upper triangle at the negative extreme
        for (int i = 0; i < MAX_SPINS - 1; i++)
        begin
            for (int j = i + 1; j < MAX_SPINS; j++)
            begin
                write_coupling(i, j, COUP_MIN);
            end
        end

        // Oversized spin count acts as the full count; all-equal spins give
        // the largest energy
        set_spin_count(63);
        evaluate(32'hFFFF_FFFF);
        evaluate(32'h0000_0000);
        set_spin_count(32);
        evaluate(32'h5555_5555);
        evaluate(32'hFFFF_0000);

        // Random phases: mostly small spin counts, writes mixed with evaluations
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                count = $urandom_range(2, 12);
            end
            else if (pick < 80)
            begin
                count = MAX_SPINS;
            end
            else
            begin
                count = $urandom_range(0, 63);
            end
            set_spin_count(count);
            steady = (phase == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 5 && k == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < 60)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        row = $urandom_range(0, MAX_SPINS - 2);
                        col = $urandom_range(row + 1, MAX_SPINS - 1);
                    end
                    else
                    begin
                        row = $urandom_range(0, MAX_SPINS - 1);
                        col = $urandom_range(0, MAX_SPINS - 1);
                    end
                    write_coupling(row, col, random_coupling());
                end
                else
                begin
                    evaluate(random_pattern());
                end
            end
        end
        steady = 1'b0;

        // Let the last results drain, then allow the pipeline to settle
        drain_results();
        repeat (20) @(posedge clk);
        $display("Covered %0d coupling writes and %0d energy evaluations",
                 tracker.writes, tracker.evals);
        $display("across %0d spin-count settings with random stalls on both sides",
                 tracker.settings);
        if (tracker.errors == 0 && tracker.pending_energy.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ipe_pkg.sv
rtl/ipe_item_if.sv
rtl/ipe_result_if.sv
rtl/ipe_cfg_if.sv
rtl/ipe_ram.sv
rtl/ipe_eval.sv
rtl/ising_pair_energy_core.sv
tb/tb_top.sv
